@@ design/lgt_pkg.sv @@
package lgt_pkg;

  localparam int KIND_BITS  = 2;
  localparam int INDEX_BITS = 6;
  localparam int FIELD_BITS = 64;

  localparam logic [KIND_BITS-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_ADVANCE = 2'd2;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [INDEX_BITS-1:0] row_index;
    logic [FIELD_BITS-1:0] row_cells;
  } cmd_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] row_data;
    logic [KIND_BITS-1:0]  done_kind;
  } rsp_item_t;

endpackage

@@ design/lgt_ram.sv @@
module lgt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/lgt_lane.sv @@
module lgt_lane (
  input  logic [7:0] nbrs,
  input  logic       alive,
  output logic       next_alive
);

  logic [3:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(nbrs[i]);
    end
    // Birth on three neighbors, survival on two or three.
    next_alive = (count == 4'd3) || ((count == 4'd2) && alive);
  end

endmodule

@@ design/lgt_row_next.sv @@
module lgt_row_next #(
  parameter int GRID_WIDTH = 64
) (
  input  logic [GRID_WIDTH-1:0] above,
  input  logic [GRID_WIDTH-1:0] cur,
  input  logic [GRID_WIDTH-1:0] below,
  output logic [GRID_WIDTH-1:0] next_row
);

  logic [GRID_WIDTH-1:0] lane_out;

  for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_lane
    localparam int L = (x == 0) ? GRID_WIDTH - 1 : x - 1;
    localparam int R = (x == GRID_WIDTH - 1) ? 0 : x + 1;

    lgt_lane u_lane (
      .nbrs       ({above[L], above[x], above[R], cur[L], cur[R],
                    below[L], below[x], below[R]}),
      .alive      (cur[x]),
      .next_alive (lane_out[x])
    );
  end

  // The lanes' single-cell results are gathered into one row word.
  always_comb begin
    for (int x = 0; x < GRID_WIDTH; x++) begin
      next_row[x] = lane_out[x];
    end
  end

endmodule

@@ design/life_generation_torus.sv @@
// Toroidal B3/S23 life grid of GRID_HEIGHT rows by GRID_WIDTH cells, held in
// a single-port-write, single-port-read RAM of one row per word. A command
// either writes a row, reads a row or advances the whole grid one generation;
// each command gives exactly one response, and a command of any other kind
// only gets a zero response. Only rows 0..GRID_HEIGHT-1 are addressable; a
// write to a missing row is dropped and a read of one returns zero. After
// reset a clearing pass zeroes the grid, during which cmd_ready stays low.
// An advance sweep fetches row y + 2 while it writes back row y, one row per
// cycle through the RAM ports, with GRID_WIDTH parallel cell lanes computing
// a whole row in each cycle. A command is taken while the previous response
// still waits in the output register.
module life_generation_torus #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  lgt_pkg::cmd_item_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output lgt_pkg::rsp_item_t rsp
);

  import lgt_pkg::*;

  localparam int AW = $clog2(GRID_HEIGHT);
  localparam logic [AW-1:0] LAST_ROW = AW'(GRID_HEIGHT - 1);
  localparam logic [AW:0]   HEIGHT_W = (AW + 1)'(GRID_HEIGHT);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_ADV_A  = 8'b0000_1000,
    S_ADV_B  = 8'b0001_0000,
    S_SWEEP  = 8'b0010_0000,
    S_FINISH = 8'b0100_0000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]         row_ptr;
  logic [AW:0]           ahead;
  logic                  ahead_ok;
  logic                  cmd_hit;
  logic [AW-1:0]         cmd_addr;
  logic                  slot_free;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [GRID_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [GRID_WIDTH-1:0] ram_rdata;

  logic [GRID_WIDTH-1:0] first_row;
  logic [GRID_WIDTH-1:0] prev_row;
  logic [GRID_WIDTH-1:0] cur_row;
  logic [GRID_WIDTH-1:0] below_row;
  logic [GRID_WIDTH-1:0] new_row;

  logic [FIELD_BITS-1:0] pend_data;
  logic [KIND_BITS-1:0]  pend_kind;
  logic                  read_hit;

  lgt_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lgt_row_next #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_row_next (
    .above    (prev_row),
    .cur      (cur_row),
    .below    (below_row),
    .next_row (new_row)
  );

  assign cmd_hit   = 32'(cmd.row_index) < 32'(GRID_HEIGHT);
  assign cmd_addr  = AW'(cmd.row_index);
  assign ahead     = {1'b0, row_ptr} + (AW + 1)'(2);
  assign ahead_ok  = ahead < HEIGHT_W;
  assign below_row = (row_ptr == LAST_ROW) ? first_row : ram_rdata;
  assign slot_free = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = row_ptr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (row_ptr == LAST_ROW) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            KIND_WRITE: begin
              ram_we     = cmd_hit;
              ram_waddr  = cmd_addr;
              ram_wdata  = cmd.row_cells[GRID_WIDTH-1:0];
              state_next = S_FINISH;
            end
            KIND_READ: begin
              ram_re     = cmd_hit;
              ram_raddr  = cmd_addr;
              state_next = S_READ;
            end
            KIND_ADVANCE: begin
              ram_re     = 1'b1;
              state_next = S_ADV_A;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_FINISH;
      end
      S_ADV_A: begin
        ram_re     = 1'b1;
        ram_raddr  = LAST_ROW;
        state_next = S_ADV_B;
      end
      S_ADV_B: begin
        ram_re     = 1'b1;
        ram_raddr  = AW'(1);
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        // Row y is rewritten while row y + 2, if it exists, is fetched for the next cycle.
        ram_we    = 1'b1;
        ram_wdata = new_row;
        ram_re    = ahead_ok;
        ram_raddr = ahead[AW-1:0];
        if (row_ptr == LAST_ROW) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      row_ptr   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_CLEAR || state == S_SWEEP) begin
        row_ptr <= row_ptr + AW'(1);
      end else if (state == S_ADV_B) begin
        row_ptr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          pend_kind <= cmd.kind;
          pend_data <= '0;
          read_hit  <= cmd_hit;
        end
      end
      S_READ: begin
        pend_data <= read_hit ? FIELD_BITS'(ram_rdata) : '0;
      end
      S_ADV_A: begin
        first_row <= ram_rdata;
      end
      S_ADV_B: begin
        prev_row <= ram_rdata;
        cur_row  <= first_row;
      end
      S_SWEEP: begin
        prev_row <= cur_row;
        cur_row  <= ram_rdata;
      end
      S_FINISH: begin
        if (slot_free) begin
          rsp.row_data  <= pend_data;
          rsp.done_kind <= pend_kind;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_write_finishes: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.kind == KIND_WRITE) |=> state == S_FINISH)
    else $error("write command did not go straight to the response stage");

  a_sweep_covers_rows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && row_ptr != LAST_ROW) |=> state == S_SWEEP)
    else $error("generation sweep ended before the last row");

  a_ram_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ({1'b0, ram_waddr} < HEIGHT_W))
    else $error("grid write beyond the last row");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FINISH))
    else $error("response raised outside the response stage");
`endif

endmodule

@@ sim/tb_life_generation_torus.sv @@
`timescale 1ns / 1ps

module tb_life_generation_torus;
  import lgt_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 184;

  class life_scoreboard;
    logic [COLS-1:0] grid [ROWS];
    rsp_item_t expected_q [$];
    int errors;
    int checked;
    int kind_count [4];

    function new();
      foreach (grid[y]) grid[y] = '0;
      foreach (kind_count[k]) kind_count[k] = 0;
      errors = 0;
      checked = 0;
    endfunction

    // One B3/S23 generation with wrap-around on both axes.
    function void evolve_grid();
      logic [COLS-1:0] prev [ROWS];
      int live;
      prev = grid;
      for (int y = 0; y < ROWS; y++) begin
        for (int x = 0; x < COLS; x++) begin
          live = 0;
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              if (dy != 0 || dx != 0) begin
                live += prev[(y + dy + ROWS) % ROWS][(x + dx + COLS) % COLS];
              end
            end
          end
          grid[y][x] = (live == 3) || (live == 2 && prev[y][x]);
        end
      end
    endfunction

    function void note_command(cmd_item_t c);
      rsp_item_t r;
      r.row_data = '0;
      r.done_kind = c.kind;
      case (c.kind)
        KIND_WRITE: grid[c.row_index] = c.row_cells;
        KIND_READ: r.row_data = grid[c.row_index];
        KIND_ADVANCE: evolve_grid();
        default: ;
      endcase
      kind_count[c.kind]++;
      expected_q.push_back(r);
    endfunction

    function void check_response(rsp_item_t r);
      rsp_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response row_data=%h done_kind=%0d",
                 $time, r.row_data, r.done_kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (r.row_data !== e.row_data) begin
        $display("%0t: row_data mismatch: expected %h, got %h", $time, e.row_data, r.row_data);
        errors++;
      end
      if (r.done_kind !== e.done_kind) begin
        $display("%0t: done_kind mismatch: expected %0d, got %0d",
                 $time, e.done_kind, r.done_kind);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_item_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_item_t rsp;

  life_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int items_sent = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  life_generation_torus DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, sb.expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Response side: checks each transfer, then picks the next ready level.
  // A new hold-off request stalls the response channel for a long stretch.
  initial begin : rsp_side
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
        sb.check_response(rsp);
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Valid stays high across back-to-back transfers; it is lowered only for a gap.
  task automatic send_item(input cmd_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    sb.note_command(item);
    items_sent++;
  endtask

  task automatic do_cmd(input logic [KIND_BITS-1:0] kind, input logic [INDEX_BITS-1:0] idx,
                        input logic [FIELD_BITS-1:0] cells);
    cmd_item_t item;
    item.kind = kind;
    item.row_index = idx;
    item.row_cells = cells;
    send_item(item);
  endtask

  function automatic logic [FIELD_BITS-1:0] rand_cells();
    logic [FIELD_BITS-1:0] shape;
    int k;
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: return {$urandom, $urandom} | {$urandom, $urandom};
      default: begin
        shape = 64'($urandom_range(7));
        k = $urandom_range(63);
        return (shape << k) | (shape >> (64 - k));
      end
    endcase
  endfunction

  // Load a band of neighboring rows, evolve it, then read it back with a
  // margin of one row on each side.
  task automatic run_episode();
    int base;
    int band;
    int gens;
    base = $urandom_range(ROWS - 1);
    band = $urandom_range(2, 8);
    gens = $urandom_range(1, 3);
    for (int i = 0; i < band; i++) begin
      do_cmd(KIND_WRITE, 6'((base + i) % ROWS), rand_cells());
    end
    repeat (gens) do_cmd(KIND_ADVANCE, 6'($urandom), rand_cells());
    for (int i = -1; i <= band; i++) begin
      do_cmd(KIND_READ, 6'((base + i + ROWS) % ROWS), rand_cells());
    end
  endtask

  task automatic run_random(input int count);
    int stop;
    int pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        run_episode();
      end else if (pick < 85) begin
        do_cmd(2'($urandom_range(3)), 6'($urandom), rand_cells());
      end else begin
        repeat ($urandom_range(1, 4)) do_cmd(KIND_READ, 6'($urandom), rand_cells());
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Extreme rows and columns, wrap across both edges, and the unused kind.
    do_cmd(KIND_READ, 6'd0, '0);
    do_cmd(KIND_WRITE, 6'd0, '1);
    do_cmd(KIND_READ, 6'd0, '0);
    do_cmd(KIND_WRITE, 6'd63, 64'h8000_0000_0000_0001);
    do_cmd(KIND_READ, 6'd63, '1);
    do_cmd(KIND_ADVANCE, 6'd0, '0);
    do_cmd(KIND_READ, 6'd0, '0);
    do_cmd(KIND_READ, 6'd63, '0);
    do_cmd(KIND_READ, 6'd1, '0);
    do_cmd(KIND_UNUSED, 6'd63, '1);
    do_cmd(KIND_READ, 6'd63, '0);
    do_cmd(KIND_WRITE, 6'd0, 64'h8000_0000_0000_0003);
    do_cmd(KIND_ADVANCE, 6'd63, '1);
    do_cmd(KIND_READ, 6'd63, '0);
    do_cmd(KIND_READ, 6'd0, '0);
    do_cmd(KIND_READ, 6'd1, '0);
    do_cmd(KIND_ADVANCE, 6'd0, '0);
    do_cmd(KIND_READ, 6'd0, '0);
    do_cmd(KIND_UNUSED, 6'd0, '0);

    send_idle_pct = 33;
    recv_idle_pct = 81;
    run_random(PHASE_ITEMS);

    send_idle_pct = 81;
    recv_idle_pct = 33;
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    run_random(PHASE_ITEMS);

    cmd_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses: %0d row writes, %0d row reads, %0d generations, %0d unused",
             sb.checked, sb.kind_count[KIND_WRITE], sb.kind_count[KIND_READ],
             sb.kind_count[KIND_ADVANCE], sb.kind_count[KIND_UNUSED]);
    $display("Stimulus ran under both stall mixes, no stalls, and one long response stall.");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
